/* src/miws_pkg.sv */
// Shared constants, widths and types for the metric inverse and wave speed block.
// Used by the divider lane, the square root unit and the top level; no dependencies.
`default_nettype none

package miws_pkg;

	// Fraction bits of the fixed point format.
	localparam int FRAC_BITS = 24;

	// Width of a result word and of the quotient and root magnitudes.
	localparam int QW = 32;

	// Twice an adjugate entry, a signed value that stays below 2^68 in magnitude.
	localparam int TW = 70;
	// Determinant, signed, below 2^96 in magnitude.
	localparam int DETW = 98;
	// Left shift that turns twice the adjugate entry into the scaled numerator.
	localparam int SHL = 2 * FRAC_BITS - 1;
	// Rounded numerator 2|t|*2^SHL + |det| and doubled divisor 2|det|.
	localparam int NW = TW + SHL + 1;
	localparam int DW = DETW + 1;
	// Divider remainder, wide enough for the divisor shifted by the quotient width.
	localparam int RW = (NW > DW + QW) ? NW : DW + QW;
	// Divider lane depth: overflow check, one stage per quotient bit, saturation.
	localparam int DIV_LAT = QW + 2;

	// Square root: radicand width and remainder width.
	localparam int XW = 2 * QW;
	localparam int RMW = QW + 2;

	// Harmonic product lapse^2 * inv_00 before the fraction shift.
	localparam int HW = 94;

	localparam logic signed [QW-1:0] INV_MAX = {1'b0, {(QW-1){1'b1}}};
	localparam logic signed [QW-1:0] INV_MIN = {1'b1, {(QW-1){1'b0}}};
	localparam logic [QW-2:0] SPEED_MAX = {(QW-1){1'b1}};

	typedef enum logic [1:0] {
		MODE_GEODESIC     = 2'd0,
		MODE_HARMONIC     = 2'd1,
		MODE_ONE_PLUS_LOG = 2'd2
	} slicing_mode_t;

	// Sign and zero information that a divider lane needs to finish its entry.
	typedef struct packed {
		logic neg;
		logic t_zero;
		logic t_neg;
		logic det_zero;
	} div_ctrl_t;

endpackage

`default_nettype wire

/* src/miws_div_lane.sv */
// One lane of the pipelined restoring divider: rounded, saturated adjugate / determinant.
// Depends on miws_pkg for widths, saturation limits and the lane control struct.
`default_nettype none

module miws_div_lane (
	input  logic                       clk,
	input  logic                       adv,
	input  logic [miws_pkg::NW-1:0]    num,
	input  logic [miws_pkg::DW-1:0]    dvs,
	input  miws_pkg::div_ctrl_t        ctrl,
	output logic signed [miws_pkg::QW-1:0] inv
);

	logic [miws_pkg::RW-1:0]  rem_s  [miws_pkg::QW+1];
	logic [miws_pkg::DW-1:0]  dv_s   [miws_pkg::QW+1];
	logic [miws_pkg::QW-1:0]  q_s    [miws_pkg::QW+1];
	logic                     ovf_s  [miws_pkg::QW+1];
	miws_pkg::div_ctrl_t      ctrl_s [miws_pkg::QW+1];
	logic signed [miws_pkg::QW-1:0] res_c;
	logic signed [miws_pkg::QW-1:0] res_q;

	// A quotient of 2^QW or more saturates whatever its sign.
	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0]  <= miws_pkg::RW'(num);
			dv_s[0]   <= dvs;
			q_s[0]    <= '0;
			ovf_s[0]  <= miws_pkg::RW'(num) >= (miws_pkg::RW'(dvs) << miws_pkg::QW);
			ctrl_s[0] <= ctrl;
		end
	end

	for (genvar k = 1; k <= miws_pkg::QW; k++) begin : g_bit
		logic [miws_pkg::RW-1:0] trial;
		logic                    take;

		always_comb begin
			trial = miws_pkg::RW'(dv_s[k-1]) << (miws_pkg::QW - k);
			take  = rem_s[k-1] >= trial;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k]  <= take ? rem_s[k-1] - trial : rem_s[k-1];
				dv_s[k]   <= dv_s[k-1];
				q_s[k]    <= {q_s[k-1][miws_pkg::QW-2:0], take};
				ovf_s[k]  <= ovf_s[k-1];
				ctrl_s[k] <= ctrl_s[k-1];
			end
		end
	end

	always_comb begin
		if (ctrl_s[miws_pkg::QW].det_zero) begin
			if (ctrl_s[miws_pkg::QW].t_zero) begin
				res_c = '0;
			end else if (ctrl_s[miws_pkg::QW].t_neg) begin
				res_c = miws_pkg::INV_MIN;
			end else begin
				res_c = miws_pkg::INV_MAX;
			end
		end else if (ovf_s[miws_pkg::QW] || q_s[miws_pkg::QW][miws_pkg::QW-1]) begin
			res_c = ctrl_s[miws_pkg::QW].neg ? miws_pkg::INV_MIN : miws_pkg::INV_MAX;
		end else if (ctrl_s[miws_pkg::QW].neg) begin
			res_c = -$signed(q_s[miws_pkg::QW]);
		end else begin
			res_c = $signed(q_s[miws_pkg::QW]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_c;
		end
	end

	assign inv = res_q;

endmodule

`default_nettype wire

/* src/miws_isqrt.sv */
// Pipelined integer square root, two radicand bits per stage, floor result.
// Depends on miws_pkg for the radicand, root and remainder widths.
`default_nettype none

module miws_isqrt (
	input  logic                    clk,
	input  logic                    adv,
	input  logic [miws_pkg::XW-1:0] x,
	output logic [miws_pkg::QW-1:0] root
);

	logic [miws_pkg::RMW-1:0] rem_s  [miws_pkg::QW];
	logic [miws_pkg::QW-1:0]  root_s [miws_pkg::QW];
	logic [miws_pkg::XW-1:0]  x_s    [miws_pkg::QW];

	for (genvar k = 0; k < miws_pkg::QW; k++) begin : g_stage
		logic [miws_pkg::RMW-1:0] prem;
		logic [miws_pkg::QW-1:0]  proot;
		logic [miws_pkg::XW-1:0]  px;
		logic [miws_pkg::RMW+1:0] cur;
		logic [miws_pkg::RMW+1:0] trial;
		logic                     take;

		if (k == 0) begin : g_first
			assign prem  = '0;
			assign proot = '0;
			assign px    = x;
		end else begin : g_next
			assign prem  = rem_s[k-1];
			assign proot = root_s[k-1];
			assign px    = x_s[k-1];
		end

		// Bring down the next bit pair and try the root extended by a one.
		always_comb begin
			cur   = {prem, px[miws_pkg::XW-1 -: 2]};
			trial = (miws_pkg::RMW+2)'({proot, 2'b01});
			take  = cur >= trial;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k]  <= miws_pkg::RMW'(take ? cur - trial : cur);
				root_s[k] <= {proot[miws_pkg::QW-2:0], take};
				x_s[k]    <= px << 2;
			end
		end
	end

	assign root = root_s[miws_pkg::QW-1];

endmodule

`default_nettype wire

/* src/metric_inverse_and_wave_speed_top.sv */
// Metric inverse and wave speed: 3x3 Cayley-Hamilton inverse plus characteristic speed.
// One transaction per cycle is taken while the result side does not stall. The pipeline
// holds the 34 stage divider lanes (one quotient bit per stage) and the 32 stage square
// root pipeline.
// arst_n clears all valid bits and sets slicing_mode to geodesic; there is no clearing pass.
// Depends on miws_pkg, miws_div_lane and miws_isqrt.
`default_nettype none

module metric_inverse_and_wave_speed_top (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                cfg_write_enable,
	input  logic [1:0]          cfg_write_data,

	input  logic                cell_valid,
	output logic                cell_stall,
	input  logic signed [31:0]  metric_00,
	input  logic signed [31:0]  metric_01,
	input  logic signed [31:0]  metric_02,
	input  logic signed [31:0]  metric_10,
	input  logic signed [31:0]  metric_11,
	input  logic signed [31:0]  metric_12,
	input  logic signed [31:0]  metric_20,
	input  logic signed [31:0]  metric_21,
	input  logic signed [31:0]  metric_22,
	input  logic signed [31:0]  lapse_value,
	input  logic signed [31:0]  shift_x,

	output logic                result_valid,
	input  logic                result_stall,
	output logic signed [31:0]  inv_00,
	output logic signed [31:0]  inv_01,
	output logic signed [31:0]  inv_02,
	output logic signed [31:0]  inv_10,
	output logic signed [31:0]  inv_11,
	output logic signed [31:0]  inv_12,
	output logic signed [31:0]  inv_20,
	output logic signed [31:0]  inv_21,
	output logic signed [31:0]  inv_22,
	output logic [30:0]         max_speed,
	output logic                bad_input
);

	// Fields that ride alongside the divider lanes.
	typedef struct packed {
		logic signed [31:0] lapse;
		logic signed [31:0] shift;
		logic [62:0]        lsq;
		logic               det_zero;
	} div_side_t;

	// Fields that ride alongside the square root pipeline.
	typedef struct packed {
		logic [8:0][31:0]   inv;
		logic signed [31:0] shift;
		logic               flag;
		logic               big;
	} sq_side_t;

	// ------------------------------------------------------------------
	// Flow control. The whole pipeline moves as one: it advances unless the
	// result register holds a transaction that the far side is stalling.
	// Bubbles travel with their valid bits, so a stall neither loses nor
	// repeats a transaction.
	// ------------------------------------------------------------------
	logic adv;
	assign adv        = !(result_valid && result_stall);
	assign cell_stall = !adv;

	// Configuration register; the user must write it only while the block is idle, which the block does not enforce.
	logic [1:0] slicing_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slicing_mode_q <= miws_pkg::MODE_GEODESIC;
		end else if (cfg_write_enable) begin
			slicing_mode_q <= cfg_write_data;
		end
	end

	// ------------------------------------------------------------------
	// Valid bits for every stage.
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic valid_s7, valid_s8, valid_s9;
	logic vdiv_s [miws_pkg::DIV_LAT];
	logic vsq_s  [miws_pkg::QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
			for (int i = 0; i < miws_pkg::DIV_LAT; i++) vdiv_s[i] <= 1'b0;
			for (int i = 0; i < miws_pkg::QW; i++) vsq_s[i] <= 1'b0;
		end else if (adv) begin
			valid_s1 <= cell_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			vdiv_s[0] <= valid_s6;
			for (int i = 1; i < miws_pkg::DIV_LAT; i++) vdiv_s[i] <= vdiv_s[i-1];
			valid_s7 <= vdiv_s[miws_pkg::DIV_LAT-1];
			valid_s8 <= valid_s7;
			vsq_s[0] <= valid_s8;
			for (int i = 1; i < miws_pkg::QW; i++) vsq_s[i] <= vsq_s[i-1];
			valid_s9 <= vsq_s[miws_pkg::QW-1];
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: capture the transaction. The metric is held row-major.
	// ------------------------------------------------------------------
	logic signed [31:0] g_in [9];
	logic signed [31:0] g_s1 [9];
	logic signed [31:0] lapse_s1, shift_s1;

	assign g_in[0] = metric_00;
	assign g_in[1] = metric_01;
	assign g_in[2] = metric_02;
	assign g_in[3] = metric_10;
	assign g_in[4] = metric_11;
	assign g_in[5] = metric_12;
	assign g_in[6] = metric_20;
	assign g_in[7] = metric_21;
	assign g_in[8] = metric_22;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int n = 0; n < 9; n++) g_s1[n] <= g_in[n];
			lapse_s1 <= lapse_value;
			shift_s1 <= shift_x;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: all 32x32 products of the matrix square and of the 2x2 minors
	// of rows one and two, the trace, and the lapse squared.
	// ------------------------------------------------------------------
	logic signed [63:0] prod_s2 [27];
	logic signed [63:0] minp_s2 [6];
	logic signed [33:0] tr_s2;
	logic signed [31:0] g_s2 [9];
	logic signed [31:0] lapse_s2, shift_s2;
	logic [62:0]        lsq_s2;
	logic signed [63:0] lsq_c;

	assign lsq_c = lapse_s1 * lapse_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					for (int k = 0; k < 3; k++) begin
						prod_s2[i*9 + j*3 + k] <= g_s1[i*3 + k] * g_s1[k*3 + j];
					end
				end
			end
			minp_s2[0] <= g_s1[4] * g_s1[8];
			minp_s2[1] <= g_s1[7] * g_s1[5];
			minp_s2[2] <= g_s1[3] * g_s1[8];
			minp_s2[3] <= g_s1[5] * g_s1[6];
			minp_s2[4] <= g_s1[3] * g_s1[7];
			minp_s2[5] <= g_s1[4] * g_s1[6];
			tr_s2 <= 34'(g_s1[0]) + 34'(g_s1[4]) + 34'(g_s1[8]);
			for (int n = 0; n < 9; n++) g_s2[n] <= g_s1[n];
			lapse_s2 <= lapse_s1;
			shift_s2 <= shift_s1;
			lsq_s2   <= lsq_c[62:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: square entries, minors, trace times metric and trace squared.
	// ------------------------------------------------------------------
	logic signed [65:0] sq_s3    [9];
	logic signed [65:0] trg_s3   [9];
	logic signed [64:0] minor_s3 [3];
	logic signed [67:0] trtr_s3;
	logic signed [31:0] g0_s3    [3];
	logic signed [31:0] lapse_s3, shift_s3;
	logic [62:0]        lsq_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int n = 0; n < 9; n++) begin
				sq_s3[n]  <= 66'(prod_s2[n*3]) + 66'(prod_s2[n*3 + 1]) + 66'(prod_s2[n*3 + 2]);
				trg_s3[n] <= tr_s2 * g_s2[n];
			end
			minor_s3[0] <= 65'(minp_s2[0]) - 65'(minp_s2[1]);
			minor_s3[1] <= 65'(minp_s2[2]) - 65'(minp_s2[3]);
			minor_s3[2] <= 65'(minp_s2[4]) - 65'(minp_s2[5]);
			trtr_s3 <= tr_s2 * tr_s2;
			for (int j = 0; j < 3; j++) g0_s3[j] <= g_s2[j];
			lapse_s3 <= lapse_s2;
			shift_s3 <= shift_s2;
			lsq_s3   <= lsq_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: the scalar c = tr^2 - tr(g^2), the off-trace parts of the
	// adjugate, and the row-zero cofactor products. Each minor is split into
	// a signed high part and an unsigned low word to keep the multipliers
	// near 32 by 32 bits.
	// ------------------------------------------------------------------
	logic signed [68:0] c_s4;
	logic signed [66:0] d_s4    [9];
	logic signed [64:0] dplo_s4 [3];
	logic signed [64:0] dphi_s4 [3];
	logic signed [31:0] lapse_s4, shift_s4;
	logic [62:0]        lsq_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s4 <= 69'(trtr_s3) - 69'(sq_s3[0]) - 69'(sq_s3[4]) - 69'(sq_s3[8]);
			for (int n = 0; n < 9; n++) d_s4[n] <= 67'(sq_s3[n]) - 67'(trg_s3[n]);
			for (int j = 0; j < 3; j++) begin
				dplo_s4[j] <= g0_s3[j] * $signed({1'b0, minor_s3[j][31:0]});
				dphi_s4[j] <= g0_s3[j] * $signed(minor_s3[j][64:32]);
			end
			lapse_s4 <= lapse_s3;
			shift_s4 <= shift_s3;
			lsq_s4   <= lsq_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: twice each adjugate entry and the determinant.
	// ------------------------------------------------------------------
	logic signed [miws_pkg::TW-1:0]   t_s5 [9];
	logic signed [miws_pkg::DETW-1:0] det_s5;
	logic signed [miws_pkg::DETW-1:0] det_c;
	logic signed [31:0]               lapse_s5, shift_s5;
	logic [62:0]                      lsq_s5;

	always_comb begin
		logic signed [miws_pkg::DETW-1:0] term [3];
		for (int j = 0; j < 3; j++) begin
			term[j] = (miws_pkg::DETW'(dphi_s4[j]) <<< 32) + miws_pkg::DETW'(dplo_s4[j]);
		end
		det_c = term[0] - term[1] + term[2];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int n = 0; n < 9; n++) begin
				t_s5[n] <= (miws_pkg::TW'(d_s4[n]) <<< 1)
					+ ((n % 4 == 0) ? miws_pkg::TW'(c_s4) : miws_pkg::TW'(0));
			end
			det_s5   <= det_c;
			lapse_s5 <= lapse_s4;
			shift_s5 <= shift_s4;
			lsq_s5   <= lsq_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: divider operands. Rounding to nearest with ties away from zero
	// is floor((2|t|*2^SHL + |det|) / (2|det|)) with the sign applied after.
	// ------------------------------------------------------------------
	logic [miws_pkg::NW-1:0] num_s6  [9];
	miws_pkg::div_ctrl_t     ctrl_s6 [9];
	logic [miws_pkg::DW-1:0] dvs_s6;
	div_side_t               side_s6;
	logic [miws_pkg::DETW-1:0] abs_det_c;

	assign abs_det_c = det_s5[miws_pkg::DETW-1] ? miws_pkg::DETW'(-det_s5)
		: miws_pkg::DETW'(det_s5);

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int n = 0; n < 9; n++) begin
				num_s6[n] <= (miws_pkg::NW'(t_s5[n][miws_pkg::TW-1] ? -t_s5[n] : t_s5[n])
					<< (miws_pkg::SHL + 1)) + miws_pkg::NW'(abs_det_c);
				ctrl_s6[n].neg      <= t_s5[n][miws_pkg::TW-1] ^ det_s5[miws_pkg::DETW-1];
				ctrl_s6[n].t_zero   <= t_s5[n] == '0;
				ctrl_s6[n].t_neg    <= t_s5[n][miws_pkg::TW-1];
				ctrl_s6[n].det_zero <= det_s5 == '0;
			end
			dvs_s6 <= miws_pkg::DW'(abs_det_c) << 1;
			side_s6.lapse    <= lapse_s5;
			side_s6.shift    <= shift_s5;
			side_s6.lsq      <= lsq_s5;
			side_s6.det_zero <= det_s5 == '0;
		end
	end

	// ------------------------------------------------------------------
	// Nine divider lanes, one quotient bit per stage; the side fields travel
	// in a matching delay line.
	// ------------------------------------------------------------------
	logic signed [31:0] inv_div [9];
	div_side_t          side_s  [miws_pkg::DIV_LAT];

	for (genvar n = 0; n < 9; n++) begin : g_lane
		miws_div_lane u_div (
			.clk  (clk),
			.adv  (adv),
			.num  (num_s6[n]),
			.dvs  (dvs_s6),
			.ctrl (ctrl_s6[n]),
			.inv  (inv_div[n])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= side_s6;
			for (int i = 1; i < miws_pkg::DIV_LAT; i++) side_s[i] <= side_s[i-1];
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: speed flags and the products that feed the root argument.
	// Harmonic slicing takes lapse^2 * inv_00 in two halves; one-plus-log
	// slicing takes |lapse| * |inv_00|.
	// ------------------------------------------------------------------
	div_side_t          dside;
	logic signed [31:0] inv0_c;
	logic [31:0]        abs_i_c, abs_l_c;
	logic               mode_h_c, mode_l_c, bad_h_c, bad_l_c;

	logic [63:0]        hlo_s7;
	logic [61:0]        hhi_s7;
	logic [63:0]        lp_s7;
	logic               use_h_s7, use_l_s7, flag_s7;
	logic signed [31:0] shift_s7;
	logic signed [31:0] inv_s7 [9];

	assign dside   = side_s[miws_pkg::DIV_LAT-1];
	assign inv0_c  = inv_div[0];
	assign abs_i_c = inv0_c[31] ? 32'(-inv0_c) : 32'(inv0_c);
	assign abs_l_c = dside.lapse[31] ? 32'(-dside.lapse) : 32'(dside.lapse);
	assign mode_h_c = slicing_mode_q == miws_pkg::MODE_HARMONIC;
	assign mode_l_c = slicing_mode_q == miws_pkg::MODE_ONE_PLUS_LOG;
	assign bad_h_c  = inv0_c[31];
	assign bad_l_c  = (dside.lapse == '0)
		|| ((inv0_c != '0) && (inv0_c[31] != dside.lapse[31]));

	always_ff @(posedge clk) begin
		if (adv) begin
			hlo_s7   <= dside.lsq[31:0] * inv0_c[30:0];
			hhi_s7   <= dside.lsq[62:32] * inv0_c[30:0];
			lp_s7    <= abs_l_c * abs_i_c;
			use_h_s7 <= !dside.det_zero && mode_h_c && !bad_h_c;
			use_l_s7 <= !dside.det_zero && mode_l_c && !bad_l_c;
			flag_s7  <= dside.det_zero || (mode_h_c && bad_h_c) || (mode_l_c && bad_l_c);
			shift_s7 <= dside.shift;
			for (int n = 0; n < 9; n++) inv_s7[n] <= inv_div[n];
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: root argument. A harmonic argument of 2^64 or more can only
	// saturate the speed, so it is carried as a flag.
	// ------------------------------------------------------------------
	logic [miws_pkg::HW-1:0] hfull_c, hsh_c;
	sq_side_t                sqside_s8;
	logic [miws_pkg::XW-1:0] x_s8;

	assign hfull_c = (miws_pkg::HW'(hhi_s7) << 32) + miws_pkg::HW'(hlo_s7);
	assign hsh_c   = hfull_c >> miws_pkg::FRAC_BITS;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (use_h_s7) begin
				x_s8 <= hsh_c[miws_pkg::XW-1:0];
			end else if (use_l_s7) begin
				x_s8 <= lp_s7;
			end else begin
				x_s8 <= '0;
			end
			sqside_s8.big   <= use_h_s7 && (|hsh_c[miws_pkg::HW-1:miws_pkg::XW]);
			sqside_s8.flag  <= flag_s7;
			sqside_s8.shift <= shift_s7;
			for (int n = 0; n < 9; n++) sqside_s8.inv[n] <= inv_s7[n];
		end
	end

	// ------------------------------------------------------------------
	// Square root pipeline with its side delay line.
	// ------------------------------------------------------------------
	logic [miws_pkg::QW-1:0] root_c;
	sq_side_t                sqside_s [miws_pkg::QW];

	miws_isqrt u_isqrt (
		.clk  (clk),
		.adv  (adv),
		.x    (x_s8),
		.root (root_c)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sqside_s[0] <= sqside_s8;
			for (int i = 1; i < miws_pkg::QW; i++) sqside_s[i] <= sqside_s[i-1];
		end
	end

	// ------------------------------------------------------------------
	// Stage 9: speed = |shift| + root, saturated, into the result register.
	// ------------------------------------------------------------------
	sq_side_t           oside;
	logic [31:0]        abs_s_c;
	logic [32:0]        speed_c;
	logic signed [31:0] inv_s9 [9];
	logic [30:0]        speed_s9;
	logic               flag_s9;

	assign oside   = sqside_s[miws_pkg::QW-1];
	assign abs_s_c = oside.shift[31] ? 32'(-oside.shift) : 32'(oside.shift);
	assign speed_c = 33'(abs_s_c) + 33'(root_c);

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int n = 0; n < 9; n++) inv_s9[n] <= oside.inv[n];
			if (oside.big || (speed_c > 33'(miws_pkg::SPEED_MAX))) begin
				speed_s9 <= miws_pkg::SPEED_MAX;
			end else begin
				speed_s9 <= speed_c[30:0];
			end
			flag_s9 <= oside.flag;
		end
	end

	assign result_valid = valid_s9;
	assign inv_00    = inv_s9[0];
	assign inv_01    = inv_s9[1];
	assign inv_02    = inv_s9[2];
	assign inv_10    = inv_s9[3];
	assign inv_11    = inv_s9[4];
	assign inv_12    = inv_s9[5];
	assign inv_20    = inv_s9[6];
	assign inv_21    = inv_s9[7];
	assign inv_22    = inv_s9[8];
	assign max_speed = speed_s9;
	assign bad_input = flag_s9;

`ifndef NO_ASSERTIONS
	// Under geodesic slicing the flag comes only from a singular metric, whose
	// entries are pinned to the saturation limits or zero.
	a_singular_inv: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && bad_input && slicing_mode_q == miws_pkg::MODE_GEODESIC)
		|-> (inv_00 == miws_pkg::INV_MAX || inv_00 == miws_pkg::INV_MIN || inv_00 == '0))
		else $error("singular metric gave an unsaturated inverse entry");

	// A clean harmonic result always had a nonnegative inv_00.
	a_harmonic_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !bad_input && slicing_mode_q == miws_pkg::MODE_HARMONIC)
		|-> !inv_00[31])
		else $error("harmonic result with negative inv_00 not flagged");

	// A stalled result freezes the whole pipeline, the entry stage included.
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> $stable(valid_s1))
		else $error("pipeline moved while the result was stalled");
`endif

endmodule

`default_nettype wire

/* bench/tb_metric_inverse_and_wave_speed_top.sv */
// Self-checking bench for metric_inverse_and_wave_speed_top: a clocked driver and monitor,
// with an expected-result queue filled by a wide-integer model of inverse and speed.
// Depends on miws_pkg and the block under test.
`timescale 1ns / 100ps

module tb_metric_inverse_and_wave_speed_top;

	// One cell as offered on the input channel.
	typedef struct {
		logic signed [31:0] m [9];
		logic signed [31:0] lapse;
		logic signed [31:0] shift;
	} cell_t;

	// One result transaction as it should leave the block.
	typedef struct {
		logic signed [31:0] inv [9];
		logic [30:0]        speed;
		logic               bad;
	} cell_result_t;

	// Wide enough that no intermediate of the inverse can overflow.
	typedef logic signed [255:0] wide_t;

	localparam int DRAIN_CYCLES = 120;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ITEMS = 1800;

	// Extreme signed words, also the saturation limits of an inverse entry.
	localparam logic signed [31:0] W_MAX = miws_pkg::INV_MAX;
	localparam logic signed [31:0] W_MIN = miws_pkg::INV_MIN;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write_enable = 1'b0;
	logic [1:0] cfg_write_data = '0;
	logic cell_valid = 1'b0;
	logic cell_stall;
	logic signed [31:0] m_in [9];
	logic signed [31:0] lapse_value = '0;
	logic signed [31:0] shift_x = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [31:0] inv_out [9];
	logic [30:0] max_speed;
	logic bad_input;

	cell_t        pending_cells [$];
	cell_result_t expected_results [$];
	logic [1:0]   slicing_copy = miws_pkg::MODE_GEODESIC;
	int           error_count = 0;
	int           results_checked = 0;
	int           cycle_count = 0;
	bit           steady_mode = 1'b0;

	initial begin
		for (int i = 0; i < 9; i++) m_in[i] = '0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	metric_inverse_and_wave_speed_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write_enable(cfg_write_enable), .cfg_write_data(cfg_write_data),
		.cell_valid(cell_valid), .cell_stall(cell_stall),
		.metric_00(m_in[0]), .metric_01(m_in[1]), .metric_02(m_in[2]),
		.metric_10(m_in[3]), .metric_11(m_in[4]), .metric_12(m_in[5]),
		.metric_20(m_in[6]), .metric_21(m_in[7]), .metric_22(m_in[8]),
		.lapse_value(lapse_value), .shift_x(shift_x),
		.result_valid(result_valid), .result_stall(result_stall),
		.inv_00(inv_out[0]), .inv_01(inv_out[1]), .inv_02(inv_out[2]),
		.inv_10(inv_out[3]), .inv_11(inv_out[4]), .inv_12(inv_out[5]),
		.inv_20(inv_out[6]), .inv_21(inv_out[7]), .inv_22(inv_out[8]),
		.max_speed(max_speed), .bad_input(bad_input)
	);

	// Integer square root, rounded down, built one bit at a time from the top.
	function automatic logic [32:0] root_floor(logic [63:0] x);
		logic [32:0] r;
		logic [32:0] trial;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = r | (33'd1 << b);
			if ({33'd0, trial} * {33'd0, trial} <= {2'd0, x}) r = trial;
		end
		return r;
	endfunction

	// Computes the inverse metric and the characteristic speed of one cell.
	function automatic cell_result_t inverse_and_speed(cell_t c, logic [1:0] mode);
		cell_result_t res;
		wide_t g [3][3];
		wide_t sq [3][3];
		wide_t tr, trsq, cc, det, t, n, d, q, p, root;
		wide_t lw, iw, sw, speed;
		logic neg;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				g[i][j] = wide_t'(c.m[3*i+j]);
		tr = g[0][0] + g[1][1] + g[2][2];
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				sq[i][j] = g[i][0]*g[0][j] + g[i][1]*g[1][j] + g[i][2]*g[2][j];
		trsq = sq[0][0] + sq[1][1] + sq[2][2];
		cc = tr*tr - trsq;
		det = g[0][0]*(g[1][1]*g[2][2] - g[2][1]*g[1][2])
			- g[0][1]*(g[1][0]*g[2][2] - g[1][2]*g[2][0])
			+ g[0][2]*(g[1][0]*g[2][1] - g[1][1]*g[2][0]);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				// t is twice the adjugate entry.
				t = 2 * (sq[i][j] - tr*g[i][j]);
				if (i == j) t = t + cc;
				if (det == 0) begin
					res.inv[3*i+j] = (t == 0) ? 32'sd0 : (t < 0 ? W_MIN : W_MAX);
				end else begin
					t = t <<< miws_pkg::SHL;
					neg = (t < 0) ^ (det < 0);
					n = (t < 0) ? -t : t;
					d = (det < 0) ? -det : det;
					// Round half away from zero on the magnitude.
					q = (2*n + d) / (2*d);
					if (!neg) res.inv[3*i+j] = (q > 64'h7FFF_FFFF) ? W_MAX : q[31:0];
					else res.inv[3*i+j] = (q >= 64'h8000_0000) ? W_MIN : -q[31:0];
				end
			end
		lw = wide_t'(c.lapse);
		sw = wide_t'(c.shift);
		iw = wide_t'(res.inv[0]);
		res.bad = (det == 0);
		root = 0;
		if (det != 0 && mode == miws_pkg::MODE_HARMONIC) begin
			if (iw < 0) res.bad = 1'b1;
			else begin
				p = (lw*lw*iw) >>> miws_pkg::FRAC_BITS;
				if (p >= (wide_t'(1) <<< 64)) root = wide_t'(1) <<< 32;
				else root = wide_t'(root_floor(p[63:0]));
			end
		end else if (det != 0 && mode == miws_pkg::MODE_ONE_PLUS_LOG) begin
			if (lw == 0) res.bad = 1'b1;
			else if (iw != 0 && ((iw < 0) != (lw < 0))) res.bad = 1'b1;
			else begin
				p = (lw < 0 ? -lw : lw) * (iw < 0 ? -iw : iw);
				root = wide_t'(root_floor(p[63:0]));
			end
		end
		// Mode 3 is unused and falls through as geodesic: no root term.
		speed = (sw < 0 ? -sw : sw) + root;
		res.speed = (speed > 32'h7FFF_FFFF) ? miws_pkg::SPEED_MAX : speed[30:0];
		return res;
	endfunction

	function automatic logic signed [31:0] rand_word();
		return $urandom();
	endfunction

	// A symmetric, diagonally dominant metric with random content: the common case.
	function automatic cell_t physical_cell();
		cell_t c;
		for (int i = 0; i < 3; i++) begin
			c.m[4*i] = (32'sd1 <<< 24) * $urandom_range(1, 6) + $signed($urandom_range(0, 1 << 23));
		end
		c.m[1] = $signed($urandom_range(0, 1 << 23)) - (32'sd1 <<< 22);
		c.m[2] = $signed($urandom_range(0, 1 << 23)) - (32'sd1 <<< 22);
		c.m[5] = $signed($urandom_range(0, 1 << 23)) - (32'sd1 <<< 22);
		c.m[3] = c.m[1];
		c.m[6] = c.m[2];
		c.m[7] = c.m[5];
		c.lapse = $signed($urandom_range(0, 1 << 27)) - (($urandom_range(0, 3) == 0) ? (32'sd1 <<< 26) : 0);
		c.shift = $signed($urandom_range(0, 1 << 26)) - (32'sd1 <<< 25);
		return c;
	endfunction

	function automatic cell_t random_cell();
		cell_t c;
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 60) return physical_cell();
		for (int i = 0; i < 9; i++) c.m[i] = rand_word();
		c.lapse = rand_word();
		c.shift = rand_word();
		if (kind < 72) begin
			// Small entries keep the determinant in range, so the division matters.
			for (int i = 0; i < 9; i++) c.m[i] = c.m[i] >>> $urandom_range(4, 30);
			c.lapse = c.lapse >>> $urandom_range(0, 20);
		end else if (kind < 84) begin
			// A repeated row gives a singular metric.
			for (int j = 0; j < 3; j++) c.m[6+j] = c.m[3+j];
		end
		if ($urandom_range(0, 19) == 0) c.lapse = '0;
		return c;
	endfunction

	function automatic cell_t diag_cell(logic signed [31:0] a, logic signed [31:0] b,
			logic signed [31:0] d, logic signed [31:0] l, logic signed [31:0] s);
		cell_t c;
		for (int i = 0; i < 9; i++) c.m[i] = '0;
		c.m[0] = a;
		c.m[4] = b;
		c.m[8] = d;
		c.lapse = l;
		c.shift = s;
		return c;
	endfunction

	// Corner cases: identity, zero and singular metrics, extreme words, lapse signs,
	// negative inverse entry, and a shift large enough to saturate the speed.
	task automatic queue_corner_cells();
		cell_t c;
		logic signed [31:0] one;
		one = 32'sd1 <<< 24;
		pending_cells.push_back(diag_cell(one, one, one, one, '0));
		pending_cells.push_back(diag_cell('0, '0, '0, one, one));
		pending_cells.push_back(diag_cell(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX));
		pending_cells.push_back(diag_cell(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN));
		pending_cells.push_back(diag_cell(W_MIN, W_MAX, W_MIN, -one, 32'sd1));
		pending_cells.push_back(diag_cell(-one, one, one, one, '0));
		pending_cells.push_back(diag_cell(-one, one, one, -one, '0));
		pending_cells.push_back(diag_cell(one, one, one, '0, -32'sd1));
		pending_cells.push_back(diag_cell(one, one, one, -one, one));
		pending_cells.push_back(diag_cell(32'sd1, 32'sd1, 32'sd1, W_MAX, W_MAX));
		pending_cells.push_back(diag_cell(32'sd1, 32'sd1, 32'sd1, W_MIN, '0));
		pending_cells.push_back(diag_cell(one <<< 3, one, one, W_MAX, W_MIN));
		pending_cells.push_back(diag_cell(one >>> 8, one, one, one <<< 4, one));
		pending_cells.push_back(diag_cell(32'sd3, -32'sd5, 32'sd7, 32'sd2, -32'sd9));
		c = diag_cell(one, one, one, one, '0);
		for (int i = 0; i < 9; i++) c.m[i] = 32'hFFFF_FFFF;
		pending_cells.push_back(c);
		for (int i = 0; i < 9; i++) c.m[i] = (i % 2) ? W_MIN : W_MAX;
		pending_cells.push_back(c);
		c = physical_cell();
		c.m[1] = c.m[0];
		c.m[3] = c.m[0];
		c.m[4] = c.m[0];
		pending_cells.push_back(c);
	endtask

	function automatic int pick_gap();
		if (steady_mode) return 0;
		if ($urandom_range(0, 9) < 6) return 0;
		if ($urandom_range(0, 11) == 0) return $urandom_range(15, 60);
		return $urandom_range(1, 3);
	endfunction

	// Driver: offers queued cells, holds a payload steady while the block stalls,
	// and records the expected result of every transaction that is accepted.
	int send_gap = 0;
	always @(posedge clk) begin
		if (cell_valid && !cell_stall) begin
			cell_t acc;
			for (int i = 0; i < 9; i++) acc.m[i] = m_in[i];
			acc.lapse = lapse_value;
			acc.shift = shift_x;
			expected_results.push_back(inverse_and_speed(acc, slicing_copy));
		end
		if (!(cell_valid && cell_stall)) begin
			if (send_gap > 0 || pending_cells.size() == 0 || !arst_n) begin
				if (send_gap > 0) send_gap <= send_gap - 1;
				cell_valid <= 1'b0;
			end else begin
				cell_t nxt;
				nxt = pending_cells.pop_front();
				for (int i = 0; i < 9; i++) m_in[i] <= nxt.m[i];
				lapse_value <= nxt.lapse;
				shift_x <= nxt.shift;
				cell_valid <= 1'b1;
				send_gap <= pick_gap();
			end
		end
	end

	// Monitor: checks each accepted result against the expected queue, drives random
	// stalls on the result side, and stalls for as long as the hold-off process below is counting.
	int stall_count = 0;
	int hold_count = 0;
	bit hold_done = 1'b0;
	always @(posedge clk) begin
		if (result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$error("result transaction with no expected result");
				error_count++;
			end else begin
				cell_result_t e;
				e = expected_results.pop_front();
				for (int i = 0; i < 9; i++)
					if (inv_out[i] !== e.inv[i]) begin
						$error("inv_%0d%0d: expected %0d, got %0d", i / 3, i % 3,
							e.inv[i], inv_out[i]);
						error_count++;
					end
				if (max_speed !== e.speed) begin
					$error("max_speed: expected %0d, got %0d", e.speed, max_speed);
					error_count++;
				end
				if (bad_input !== e.bad) begin
					$error("bad_input: expected %0d, got %0d", e.bad, bad_input);
					error_count++;
				end
			end
			results_checked++;
		end
		if (hold_count > 0) begin
			result_stall <= 1'b1;
		end else if (stall_count > 0) begin
			stall_count <= stall_count - 1;
			result_stall <= 1'b1;
		end else if (!steady_mode && $urandom_range(0, 9) < 3) begin
			stall_count <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 50)
				: $urandom_range(0, 2);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// One long hold-off on the result side, started early in the first phase while
	// many cells are still queued, so the sender keeps offering and the block
	// backs up until it stalls its input.
	always @(posedge clk) begin
		if (!hold_done && results_checked >= 100) begin
			hold_done <= 1'b1;
			hold_count <= 400;
		end else if (hold_count > 0) begin
			hold_count <= hold_count - 1;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_metric_inverse_and_wave_speed_top: done, errors");
			$finish;
		end
	end

	task automatic drain_pipeline();
		wait (pending_cells.size() == 0 && !cell_valid && expected_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_slicing(logic [1:0] mode);
		@(posedge clk);
		cfg_write_enable <= 1'b1;
		cfg_write_data <= mode;
		slicing_copy <= mode;
		@(posedge clk);
		cfg_write_enable <= 1'b0;
	endtask

	// Sequencer: each slicing mode, including the unused code and the reset value,
	// gets the corner cells and a share of the random cells.
	initial begin
		logic [1:0] modes [5];
		modes = '{miws_pkg::MODE_HARMONIC, miws_pkg::MODE_ONE_PLUS_LOG, 2'd3,
			miws_pkg::MODE_GEODESIC, miws_pkg::MODE_ONE_PLUS_LOG};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// The first phase runs at the reset value of the register.
		queue_corner_cells();
		repeat (RANDOM_ITEMS / 6) pending_cells.push_back(random_cell());
		drain_pipeline();
		for (int ph = 0; ph < 5; ph++) begin
			set_slicing(modes[ph]);
			steady_mode = (ph == 3);
			queue_corner_cells();
			repeat (RANDOM_ITEMS / 6) pending_cells.push_back(random_cell());
			drain_pipeline();
		end
		if (error_count == 0) begin
			$display("tb_metric_inverse_and_wave_speed_top: done, clean");
		end else begin
			$display("tb_metric_inverse_and_wave_speed_top: done, errors");
		end
		$finish;
	end

endmodule
